@@ hdl/scsa_pkg.sv @@
// shared types and constants for the size class slot allocator
`default_nettype none

package scsa_pkg;

   // sizing
   localparam int MAX_RUN_LENGTH = 64;
   localparam int STACK_DEPTH    = 16;

   localparam int SLOT_W     = 21;
   localparam int LEN_W      = 7;
   localparam int KIND_W     = 3;
   localparam int SIZE_W     = 21;
   localparam int OFFSET_W   = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   localparam int CLS_W      = (MAX_RUN_LENGTH > 1) ? $clog2(MAX_RUN_LENGTH) : 1;
   localparam int FILL_W     = $clog2(STACK_DEPTH + 1);
   localparam int STACK_WORDS = MAX_RUN_LENGTH * STACK_DEPTH;
   localparam int STACK_AW   = (STACK_WORDS > 1) ? $clog2(STACK_WORDS) : 1;

   // request kinds
   typedef enum logic [0:0] {
      MODE_ALLOC   = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   // result codes
   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_EXHAUSTED  = 2'd1,
      STAT_BAD_LENGTH = 2'd2,
      STAT_STACK_FULL = 2'd3
   } status_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAP_KIND   = 2'd0,
      CSR_HEAP_SIZE   = 2'd1,
      CSR_HEAP_OFFSET = 2'd2
   } csr_idx_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_FILL = 2'd1,
      S_POP  = 2'd2
   } state_type;

   typedef struct packed {
      mode_type            mode;
      logic [LEN_W-1:0]    run_length;
      logic [SLOT_W-1:0]   release_start;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   start_slot;
      status_type          status;
      logic [KIND_W-1:0]   heap_tag;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/scsa_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module scsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hdl/size_class_slot_allocator.sv @@
// run allocator: bump counter plus one free stack per run length
// results: release, bump allocate and bad length are decided in the fill state, after the
//   fill ram read; an allocate served from a free stack adds a stack read and the pop state
// flow: one request in flight; a new request is taken only after the last one's result is
//   loaded; a stalled result holds a later request in its fill or pop state until it leaves
// reset: clears state, result valid, csr registers, bump counter and fill valid bits; stack words are not cleared
`default_nettype none

module size_class_slot_allocator
   import scsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   // register writes
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [KIND_W-1:0]         heap_kind_ff;
   logic [SIZE_W-1:0]         heap_size_ff;
   logic [OFFSET_W-1:0]       heap_offset_ff;
   logic [SLOT_W-1:0]         bump_ff, bump_in;
   logic                      bump_we;
   logic [MAX_RUN_LENGTH-1:0] fill_vld_ff;

   req_type                   req_ff;
   logic [CLS_W-1:0]          cls_ff;
   logic                      bad_ff;

   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      req_xfer;
   logic                      out_free;
   logic                      commit;
   logic                      req_bad;
   logic [CLS_W-1:0]          req_cls;

   logic [FILL_W-1:0]         fill_rd;
   logic [FILL_W-1:0]         fill_cur;
   logic                      fill_we;
   logic [FILL_W-1:0]         fill_wdata;

   logic                      stack_we;
   logic                      stack_re;
   logic [STACK_AW-1:0]       stack_base;
   logic [STACK_AW-1:0]       stack_push_addr;
   logic [STACK_AW-1:0]       stack_pop_addr;
   logic [SLOT_W-1:0]         stack_rd;

   logic [SLOT_W:0]           bump_sum;
   logic                      exhausted;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // length check and class of the incoming request
   assign req_bad = (req_data.run_length == '0) ||
                    (int'(req_data.run_length) > MAX_RUN_LENGTH);
   assign req_cls = CLS_W'(req_data.run_length - LEN_W'(1));

   // fill count, an entry never written reads as empty
   assign fill_cur = fill_vld_ff[cls_ff] ? fill_rd : '0;

   // stack addresses for the held class
   assign stack_base      = STACK_AW'(cls_ff) * STACK_AW'(STACK_DEPTH);
   assign stack_push_addr = stack_base + STACK_AW'(fill_cur);
   assign stack_pop_addr  = stack_base + STACK_AW'(fill_cur - FILL_W'(1));

   // bump check
   assign bump_sum  = {1'b0, bump_ff} + (SLOT_W + 1)'(req_ff.run_length);
   assign exhausted = bump_sum > {1'b0, heap_size_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (!bad_ff && req_ff.mode == MODE_ALLOC && fill_cur != '0) begin
               state_in = S_POP;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_POP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath controls and result
   always_comb begin
      commit      = 1'b0;
      fill_we     = 1'b0;
      fill_wdata  = fill_cur;
      stack_we    = 1'b0;
      stack_re    = 1'b0;
      bump_we     = 1'b0;
      bump_in     = bump_sum[SLOT_W-1:0];
      rsp_data_in = '{start_slot: '0, status: STAT_OK, heap_tag: '0};
      case (state_ff)
         S_IDLE: begin
         end
         S_FILL: begin
            if (bad_ff) begin
               commit             = out_free;
               rsp_data_in.status = STAT_BAD_LENGTH;
            end else if (req_ff.mode == MODE_RELEASE) begin
               commit = out_free;
               if (fill_cur >= FILL_W'(STACK_DEPTH)) begin
                  rsp_data_in.status = STAT_STACK_FULL;
               end else begin
                  stack_we   = out_free;
                  fill_we    = out_free;
                  fill_wdata = fill_cur + FILL_W'(1);
               end
            end else if (fill_cur != '0) begin
               // pop: shrink the count now, result comes with the stack word
               stack_re   = 1'b1;
               fill_we    = 1'b1;
               fill_wdata = fill_cur - FILL_W'(1);
            end else begin
               commit = out_free;
               if (exhausted) begin
                  rsp_data_in.status = STAT_EXHAUSTED;
               end else begin
                  bump_we                = out_free;
                  rsp_data_in.start_slot = bump_ff + SLOT_W'(heap_offset_ff);
                  rsp_data_in.heap_tag   = heap_kind_ff;
               end
            end
         end
         S_POP: begin
            commit                 = out_free;
            rsp_data_in.start_slot = stack_rd;
            rsp_data_in.heap_tag   = heap_kind_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         bump_ff        <= '0;
         fill_vld_ff    <= '0;
         heap_kind_ff   <= '0;
         heap_size_ff   <= '0;
         heap_offset_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (bump_we) begin
            bump_ff <= bump_in;
         end
         if (fill_we) begin
            fill_vld_ff[cls_ff] <= 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HEAP_KIND:   heap_kind_ff   <= csr_wdata[KIND_W-1:0];
               CSR_HEAP_SIZE:   heap_size_ff   <= csr_wdata[SIZE_W-1:0];
               CSR_HEAP_OFFSET: heap_offset_ff <= csr_wdata[OFFSET_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_data;
         cls_ff <= req_cls;
         bad_ff <= req_bad;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // per-length fill counts
   scsa_ram #(
      .WIDTH (FILL_W),
      .DEPTH (MAX_RUN_LENGTH)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (cls_ff),
      .wr_data (fill_wdata),
      .rd_en   (req_xfer),
      .rd_addr (req_cls),
      .rd_data (fill_rd)
   );

   // free stacks, one row of STACK_DEPTH words per length
   scsa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (STACK_WORDS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_push_addr),
      .wr_data (req_ff.release_start),
      .rd_en   (stack_re),
      .rd_addr (stack_pop_addr),
      .rd_data (stack_rd)
   );

`ifndef ASSERT_OFF
   // a transfer always starts the fill lookup
   a_xfer_to_fill: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_FILL)
      else $error("request transfer did not start fill lookup");

   // a result is only loaded when the output register can take it
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      commit |-> out_free)
      else $error("result loaded over a pending result");

   // stack count stays within depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> fill_wdata <= FILL_W'(STACK_DEPTH))
      else $error("fill count past stack depth");

   // push and pop never share a cycle
   a_stack_excl: assert property (@(posedge clock) disable iff (reset)
      !(stack_we && stack_re))
      else $error("stack push and pop in one cycle");

   // a pop read is always followed by the pop result state
   a_pop_next: assert property (@(posedge clock) disable iff (reset)
      stack_re |=> state_ff == S_POP)
      else $error("stack read without pop state");
`endif

endmodule

`default_nettype wire
